// ===== rtl/nlls_pkg.sv =====
// ---------------------------------------------------------------------------
// Numeric literal length scanner package
// Shared widths, limits and the item/result types of the scanner.
// ---------------------------------------------------------------------------
`default_nettype none

package nlls_pkg;

	// Width of one character code unit.
	localparam int CHAR_W = 16;

	// Width of the reported length.
	localparam int LEN_W = 12;

	// Longest length that is reported; longer literals saturate here.
	localparam int MAX_LEN = 4095;

	// Internal count holds up to MAX_LEN + 2 plus the largest single step.
	localparam int CNT_W = $clog2(MAX_LEN + 6);

	localparam logic [CNT_W-1:0] CNT_CAP = CNT_W'(MAX_LEN + 2);
	localparam logic [CNT_W-1:0] LEN_CLAMP = CNT_W'(MAX_LEN);

	// One character item as it leaves the input register.
	typedef struct packed {
		logic [CHAR_W-1:0] char_code;
		logic              scan_start;
		logic              line_end;
	} item_t;

	// Result of one step of the scanner.
	typedef struct packed {
		logic             valid;
		logic [LEN_W-1:0] number_length;
	} result_t;

endpackage

`default_nettype wire

// ===== rtl/numeric_literal_length_scanner.sv =====
// ---------------------------------------------------------------------------
// Numeric literal length scanner
// Measures the length of a numeric literal at the start of each scan.
// ---------------------------------------------------------------------------
// Usage:
// Characters arrive one item at a time on the s_axis channel: tdata holds the
// 16-bit code unit, tuser flags the first character of a scan and tlast the
// last available character of the line. Each scan that reaches a tlast item
// yields one item on the m_axis channel holding the literal length (0 when
// the scan start is not a number), saturated at 4095.
// Throughput is one character per clock while the result channel does not
// stall. An item passes through the input register and the scan state
// machine; its result, if any, is loaded into the output register that
// drives m_axis_tvalid.
// When the receiver holds m_axis_tready low with a result waiting, the input
// register stops advancing and s_axis_tready falls once it is full; no item
// is lost. Reset clears the scan state and both valid flags, and the block
// is ready for a new scan as soon as reset is released.
// ---------------------------------------------------------------------------
`default_nettype none

module numeric_literal_length_scanner (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Input character channel.
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [15:0] s_axis_tdata,  // [15:0] char_code
	input  wire logic        s_axis_tlast,  // line_end
	input  wire logic [0:0]  s_axis_tuser,  // [0] scan_start
	// Result channel.
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [15:0]      m_axis_tdata   // [11:0] number_length, [15:12] zero
);
	import nlls_pkg::*;

	// Input register.
	logic    valid_s1;
	item_t   item_s1;

	// Output register.
	logic             out_valid_q;
	logic [LEN_W-1:0] out_len_q;

	logic    out_free;
	logic    advance;
	result_t result;

	assign out_free      = !out_valid_q || m_axis_tready;
	assign advance       = valid_s1 && out_free;
	assign s_axis_tready = !valid_s1 || out_free;

	// Input register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	// Input register payload.
	always_ff @(posedge clk) begin
		if (s_axis_tready) begin
			item_s1.char_code  <= s_axis_tdata;
			item_s1.scan_start <= s_axis_tuser[0];
			item_s1.line_end   <= s_axis_tlast;
		end
	end

	nlls_scan u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (advance),
		.item   (item_s1),
		.result (result)
	);

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= result.valid;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (out_free && result.valid) begin
			out_len_q <= result.number_length;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {(16 - LEN_W)'(0), out_len_q};

endmodule

`default_nettype wire

// ===== rtl/nlls_scan.sv =====
// ---------------------------------------------------------------------------
// Numeric literal scan state machine
// Holds the scan state and advances it by one character per enabled cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module nlls_scan (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            en,
	input  wire nlls_pkg::item_t item,
	output nlls_pkg::result_t    result
);
	import nlls_pkg::*;

	typedef enum logic [2:0] {
		M_IDLE,
		M_DONE,
		M_ZERO,
		M_HEX,
		M_ZEXP,
		M_DEC,
		M_DECNEG
	} mode_t;

	typedef enum logic [1:0] {
		LA_EMPTY,
		LA_EXP,
		LA_SIGN
	} la_t;

	typedef enum logic [1:0] {
		FIN_NONE,
		FIN_SET,
		FIN_DEC,
		FIN_HEX
	} fin_t;

	localparam logic [CHAR_W-1:0] CH_ZERO  = CHAR_W'(16'h0030);
	localparam logic [CHAR_W-1:0] CH_NINE  = CHAR_W'(16'h0039);
	localparam logic [CHAR_W-1:0] CH_X     = CHAR_W'(16'h0078);
	localparam logic [CHAR_W-1:0] CH_DOT   = CHAR_W'(16'h002E);
	localparam logic [CHAR_W-1:0] CH_UP_E  = CHAR_W'(16'h0045);
	localparam logic [CHAR_W-1:0] CH_LO_E  = CHAR_W'(16'h0065);
	localparam logic [CHAR_W-1:0] CH_UP_L  = CHAR_W'(16'h004C);
	localparam logic [CHAR_W-1:0] CH_LO_L  = CHAR_W'(16'h006C);
	localparam logic [CHAR_W-1:0] CH_UP_F  = CHAR_W'(16'h0046);
	localparam logic [CHAR_W-1:0] CH_LO_F  = CHAR_W'(16'h0066);
	localparam logic [CHAR_W-1:0] CH_MINUS = CHAR_W'(16'h002D);
	localparam logic [CHAR_W-1:0] CH_PLUS  = CHAR_W'(16'h002B);
	localparam logic [CHAR_W-1:0] CH_UP_A  = CHAR_W'(16'h0041);
	localparam logic [CHAR_W-1:0] CH_LO_A  = CHAR_W'(16'h0061);

	// Saturating add of a small step to the count.
	function automatic logic [CNT_W-1:0] add_sat(input logic [CNT_W-1:0] c,
			input logic [1:0] n);
		logic [CNT_W-1:0] v;
		v = c + CNT_W'(n);
		return (v > CNT_CAP) ? CNT_CAP : v;
	endfunction

	// State registers.
	mode_t            mode_q;
	logic [CNT_W-1:0] count_q;
	logic [1:0]       dot_tally_q;
	logic             in_exp_q;
	logic             prev_dot_q;
	la_t              la0_q;
	la_t              la1_q;

	// Next-state values.
	mode_t            mode_d;
	logic [CNT_W-1:0] count_d;
	logic [1:0]       dot_tally_d;
	logic             in_exp_d;
	logic             prev_dot_d;
	la_t              la0_d;
	la_t              la1_d;

	// Character classes of the current item.
	logic [CHAR_W-1:0] ch;
	logic is_digit, is_hex, is_exp, is_sign, is_long, is_flt, is_dot;

	assign ch       = item.char_code;
	assign is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
	assign is_hex   = is_digit || ((ch >= CH_UP_A) && (ch <= CH_UP_F))
			|| ((ch >= CH_LO_A) && (ch <= CH_LO_F));
	assign is_exp   = (ch == CH_UP_E) || (ch == CH_LO_E);
	assign is_sign  = (ch == CH_PLUS) || (ch == CH_MINUS);
	assign is_long  = (ch == CH_UP_L) || (ch == CH_LO_L);
	assign is_flt   = (ch == CH_UP_F) || (ch == CH_LO_F);
	assign is_dot   = (ch == CH_DOT);

	// One character step, the end-of-line close and the result.
	always_comb begin
		fin_t             fin;
		logic             fin_has;
		logic [CNT_W-1:0] fin_val;
		logic [CNT_W-1:0] r;
		logic             run_dec;
		logic             neg;

		mode_d      = mode_q;
		count_d     = count_q;
		dot_tally_d = dot_tally_q;
		in_exp_d    = in_exp_q;
		prev_dot_d  = prev_dot_q;
		la0_d       = la0_q;
		la1_d       = la1_q;
		fin         = FIN_NONE;
		fin_has     = 1'b0;
		fin_val     = '0;
		run_dec     = 1'b0;
		r           = '0;
		neg         = 1'b0;
		result      = '0;

		if (item.scan_start) begin
			// First character of a scan picks the literal form.
			count_d     = CNT_W'(1);
			dot_tally_d = 2'd0;
			in_exp_d    = 1'b0;
			prev_dot_d  = 1'b0;
			la0_d       = LA_EMPTY;
			la1_d       = LA_EMPTY;
			priority if (ch == CH_ZERO) begin
				mode_d = M_ZERO;
			end else if (is_digit) begin
				mode_d = M_DEC;
			end else if (ch == CH_MINUS) begin
				mode_d = M_DECNEG;
			end else if (is_dot) begin
				mode_d      = M_DEC;
				dot_tally_d = 2'd1;
				prev_dot_d  = 1'b1;
			end else begin
				fin     = FIN_SET;
				fin_val = '0;
			end
		end else begin
			// Continuing characters by mode.
			unique case (mode_q)
				M_ZERO: begin
					priority if (ch == CH_X) begin
						count_d = CNT_W'(2);
						mode_d  = M_HEX;
					end else if (is_digit || is_dot) begin
						mode_d  = M_DEC;
						run_dec = 1'b1;
					end else if (is_exp) begin
						count_d = CNT_W'(2);
						mode_d  = M_ZEXP;
					end else begin
						fin     = FIN_SET;
						fin_val = (is_long || is_flt) ? CNT_W'(2) : CNT_W'(1);
					end
				end
				M_HEX: begin
					if (is_hex) begin
						count_d = add_sat(count_q, 2'd1);
					end else begin
						fin     = FIN_HEX;
						fin_has = 1'b1;
					end
				end
				M_ZEXP: begin
					priority if (la0_q == LA_SIGN) begin
						if (is_digit) begin
							count_d = add_sat(count_q, 2'd2);
							la0_d   = LA_EMPTY;
						end else begin
							fin = FIN_HEX;
						end
					end else if (is_digit) begin
						count_d = add_sat(count_q, 2'd1);
					end else if (is_sign && (count_q == CNT_W'(2))) begin
						la0_d = LA_SIGN;
					end else begin
						fin     = FIN_HEX;
						fin_has = 1'b1;
					end
				end
				M_DEC, M_DECNEG: begin
					run_dec = 1'b1;
				end
				M_IDLE, M_DONE: begin
				end
				default: begin
				end
			endcase

			// Decimal body, shared by the decimal modes and a leading zero.
			if (run_dec) begin
				if (la0_q == LA_EXP) begin
					priority if (la1_q == LA_SIGN) begin
						if (is_digit) begin
							count_d    = add_sat(count_q, 2'd3);
							in_exp_d   = 1'b1;
							prev_dot_d = 1'b0;
							la0_d      = LA_EMPTY;
							la1_d      = LA_EMPTY;
						end else begin
							fin = FIN_DEC;
						end
					end else if (is_digit) begin
						count_d    = add_sat(count_q, 2'd2);
						in_exp_d   = 1'b1;
						prev_dot_d = 1'b0;
						la0_d      = LA_EMPTY;
					end else if (is_sign) begin
						la1_d = LA_SIGN;
					end else begin
						fin = FIN_DEC;
					end
				end else begin
					priority if (is_digit) begin
						count_d    = add_sat(count_q, 2'd1);
						prev_dot_d = 1'b0;
					end else if (is_dot) begin
						if (in_exp_q || ((dot_tally_q != 2'd0) && prev_dot_q)) begin
							fin = FIN_DEC;
						end else begin
							if (dot_tally_q != 2'd2) begin
								dot_tally_d = dot_tally_q + 2'd1;
							end
							count_d    = add_sat(count_q, 2'd1);
							prev_dot_d = 1'b1;
						end
					end else if (is_exp) begin
						if (in_exp_q) begin
							fin = FIN_DEC;
						end else begin
							la0_d = LA_EXP;
						end
					end else begin
						fin     = FIN_DEC;
						fin_has = 1'b1;
					end
				end
			end
		end

		// Line end closes a scan that is still open.
		if ((fin == FIN_NONE) && item.line_end) begin
			unique case (mode_d)
				M_ZERO: begin
					fin     = FIN_SET;
					fin_val = CNT_W'(1);
				end
				M_HEX, M_ZEXP: begin
					fin = FIN_HEX;
				end
				M_DEC, M_DECNEG: begin
					fin = FIN_DEC;
				end
				M_IDLE, M_DONE: begin
				end
				default: begin
				end
			endcase
		end

		// Final length of the literal.
		neg = (mode_d == M_DECNEG);
		unique case (fin)
			FIN_SET: begin
				r = fin_val;
			end
			FIN_HEX: begin
				if (count_d == CNT_W'(2)) begin
					r = CNT_W'(1);
				end else begin
					r = count_d + CNT_W'(fin_has && (is_long || is_flt));
				end
			end
			FIN_DEC: begin
				priority if (prev_dot_d) begin
					r = count_d - CNT_W'(1);
					if (neg && (r == CNT_W'(1))) begin
						r = '0;
					end
				end else if (neg && (count_d == CNT_W'(1))) begin
					r = '0;
				end else begin
					r = count_d + CNT_W'(fin_has
							&& (((dot_tally_d == 2'd0) && is_long) || is_flt));
				end
			end
			FIN_NONE: begin
				r = count_d;
			end
			default: begin
				r = count_d;
			end
		endcase

		if (fin != FIN_NONE) begin
			count_d = (r > CNT_CAP) ? CNT_CAP : r;
			mode_d  = M_DONE;
			la0_d   = LA_EMPTY;
			la1_d   = LA_EMPTY;
		end

		// A line end on an open or decided scan reports the length.
		if (item.line_end && (mode_d != M_IDLE)) begin
			result.valid         = 1'b1;
			result.number_length = (count_d > LEN_CLAMP) ? LEN_CLAMP[LEN_W-1:0]
					: count_d[LEN_W-1:0];
			mode_d               = M_IDLE;
		end

		if (!en) begin
			result.valid = 1'b0;
		end
	end

	// State update, one character per enabled cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= M_IDLE;
			count_q     <= '0;
			dot_tally_q <= 2'd0;
			in_exp_q    <= 1'b0;
			prev_dot_q  <= 1'b0;
			la0_q       <= LA_EMPTY;
			la1_q       <= LA_EMPTY;
		end else if (en) begin
			mode_q      <= mode_d;
			count_q     <= count_d;
			dot_tally_q <= dot_tally_d;
			in_exp_q    <= in_exp_d;
			prev_dot_q  <= prev_dot_d;
			la0_q       <= la0_d;
			la1_q       <= la1_d;
		end
	end

	// A result only comes with an enabled line-end item.
	a_result_on_line_end: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> (en && item.line_end))
		else $error("result without an enabled line-end item");

	// After a result the scan is closed.
	a_idle_after_result: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |=> (mode_q == M_IDLE))
		else $error("scan still open after a result");

	// The count never passes its cap.
	a_count_capped: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_CAP)
		else $error("count above cap");

	// The dot tally stops at two.
	a_dot_tally: assert property (@(posedge clk) disable iff (!arst_n)
		dot_tally_q != 2'd3)
		else $error("dot tally overflow");

	// Exponent lookahead of a sign only follows an exponent mark.
	a_la_order: assert property (@(posedge clk) disable iff (!arst_n)
		(la1_q == LA_SIGN) |-> (la0_q == LA_EXP))
		else $error("sign lookahead without exponent lookahead");

endmodule

`default_nettype wire
